// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/lfdc_pkg.sv =====
package lfdc_pkg;

   // Filter depths
   localparam int HISTORY_DEPTH = 3;
   localparam int VOTE_SAMPLES  = 3;
   localparam int VOTE_NEED     = VOTE_SAMPLES / 2 + 1;
   localparam int HISTORY_NEED  = HISTORY_DEPTH / 2 + 1;
   localparam int SLOT_W        = $clog2(HISTORY_DEPTH + 1);
   localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

   // Wheel direction codes
   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_REV  = 2'd2;

   // Obstacle sequence hold times
   localparam logic [9:0] HOLD_STOP_MS = 10'd300;
   localparam logic [9:0] HOLD_REV_MS  = 10'd500;
   localparam logic [9:0] HOLD_LOOK_MS = 10'd700;

   localparam logic [7:0] ANGLE_MAX = 8'd180;

   // Obstacle sequence step codes
   localparam logic [1:0] STEP_STOP   = 2'd0;
   localparam logic [1:0] STEP_REV    = 2'd1;
   localparam logic [1:0] STEP_LOOK   = 2'd2;
   localparam logic [1:0] STEP_CENTER = 2'd3;

   // Register map
   typedef enum logic [2:0] {
      CSR_OBSTACLE_LIMIT = 3'd0,
      CSR_CRUISE_DUTY    = 3'd1,
      CSR_STEER_DUTY     = 3'd2,
      CSR_BACK_DUTY      = 3'd3,
      CSR_FAULT_TIMEOUT  = 3'd4,
      CSR_LINE_LEVEL     = 3'd5,
      CSR_LOOK_ANGLE     = 3'd6,
      CSR_CENTER_ANGLE   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [8:0]  obstacle_limit_cm;
      logic [7:0]  cruise_duty;
      logic [7:0]  steer_duty;
      logic [7:0]  back_duty;
      logic [15:0] fault_timeout_ms;
      logic        line_level;
      logic [7:0]  look_angle;
      logic [7:0]  center_angle;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  left_samples;
      logic [2:0]  right_samples;
      logic [19:0] echo_us;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0] left_dir;
      logic [7:0] left_duty;
      logic [1:0] right_dir;
      logic [7:0] right_duty;
      logic [7:0] servo_angle;
      logic [9:0] hold_ms;
      logic       right_faulty;
      logic       last;
   } rsp_type;

   // Servo limit
   function automatic logic [7:0] clamp_angle(input logic [7:0] a);
      clamp_angle = (a > ANGLE_MAX) ? ANGLE_MAX : a;
   endfunction

endpackage

// ===== sv/lfdc_filter.sv =====
module lfdc_filter
(
   input  logic             clock,
   input  logic             reset,
   input  logic             commit,
   input  lfdc_pkg::req_type item,
   input  lfdc_pkg::cfg_type cfg,
   output lfdc_pkg::rsp_type first_rsp,
   output logic             obstacle
);
   import lfdc_pkg::*;

   logic [HISTORY_DEPTH-1:0] left_hist_ff, left_hist_in;
   logic [HISTORY_DEPTH-1:0] right_hist_ff, right_hist_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in, slot_use;
   logic                     reliable_ff, reliable_in;
   logic [31:0]              seen_ff, seen_in;

   logic [24:0] echo_x17;
   logic [24:0] limit_bound;
   logic [1:0]  left_cnt, right_cnt;
   logic        left_vote, right_vote;
   logic [CNT_W-1:0] left_hcnt, right_hcnt;
   logic        left_on, right_on;
   logic [31:0] since_seen;
   logic [8:0]  turn_sum;
   logic [7:0]  turn_duty, ctr_angle, base_80, base_60;
   logic [26:0] prod_80, prod_60;

   // Obstacle test: 0 < floor(echo*17/1000) <= limit
   assign echo_x17    = {5'd0, item.echo_us} * 25'd17;
   assign limit_bound = ({15'd0, 1'b0, cfg.obstacle_limit_cm} + 25'd1) * 25'd1000;
   assign obstacle    = (echo_x17 >= 25'd1000) && (echo_x17 < limit_bound);

   // Raw sample votes
   assign left_cnt   = {1'b0, item.left_samples[0]} + {1'b0, item.left_samples[1]}
                     + {1'b0, item.left_samples[2]};
   assign right_cnt  = {1'b0, item.right_samples[0]} + {1'b0, item.right_samples[1]}
                     + {1'b0, item.right_samples[2]};
   assign left_vote  = (left_cnt >= 2'(VOTE_NEED));
   assign right_vote = (right_cnt >= 2'(VOTE_NEED));

   // Write the votes into the current history slot
   assign slot_use = (slot_ff < SLOT_W'(HISTORY_DEPTH)) ? slot_ff : '0;
   always_comb begin
      left_hist_in  = left_hist_ff;
      right_hist_in = right_hist_ff;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if (SLOT_W'(i) == slot_use) begin
            left_hist_in[i]  = left_vote;
            right_hist_in[i] = right_vote;
         end
      end
   end

   // History majority
   always_comb begin
      left_hcnt  = '0;
      right_hcnt = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         left_hcnt  = left_hcnt + CNT_W'(left_hist_in[i]);
         right_hcnt = right_hcnt + CNT_W'(right_hist_in[i]);
      end
   end

   assign left_on  = ((left_hcnt >= CNT_W'(HISTORY_NEED)) == cfg.line_level);
   assign right_on = ((right_hcnt >= CNT_W'(HISTORY_NEED)) == cfg.line_level);

   // Right sensor loss timeout
   assign since_seen = item.now_ms - seen_ff;
   always_comb begin
      reliable_in = reliable_ff;
      seen_in     = seen_ff;
      if (right_on) begin
         reliable_in = 1'b1;
         seen_in     = item.now_ms;
      end else if (since_seen > {16'd0, cfg.fault_timeout_ms}) begin
         reliable_in = 1'b0;
      end
   end

   assign slot_in = (slot_use == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_use + SLOT_W'(1);

   // Scaled duties: x/10 as (x*52429)>>19, exact for these ranges
   assign turn_sum  = {1'b0, cfg.steer_duty} + 9'd10;
   assign turn_duty = turn_sum[8] ? 8'd255 : turn_sum[7:0];
   assign prod_80   = {16'd0, cfg.cruise_duty, 3'd0} * 27'd52429;
   assign prod_60   = ({19'd0, cfg.cruise_duty} * 27'd6) * 27'd52429;
   assign base_80   = prod_80[26:19];
   assign base_60   = prod_60[26:19];
   assign ctr_angle = clamp_angle(cfg.center_angle);

   // First (or only) result for this item
   always_comb begin
      first_rsp              = '0;
      first_rsp.servo_angle  = ctr_angle;
      first_rsp.last         = 1'b1;
      first_rsp.right_faulty = ~reliable_in;
      if (obstacle) begin
         first_rsp.left_dir     = DIR_STOP;
         first_rsp.right_dir    = DIR_STOP;
         first_rsp.hold_ms      = HOLD_STOP_MS;
         first_rsp.right_faulty = ~reliable_ff;
         first_rsp.last         = 1'b0;
      end else if (left_on && !reliable_in) begin
         first_rsp.left_dir   = DIR_FWD;
         first_rsp.left_duty  = base_80;
         first_rsp.right_dir  = DIR_FWD;
         first_rsp.right_duty = cfg.cruise_duty;
      end else if (!left_on && !right_on) begin
         first_rsp.left_dir   = DIR_FWD;
         first_rsp.left_duty  = cfg.cruise_duty;
         first_rsp.right_dir  = DIR_FWD;
         first_rsp.right_duty = cfg.cruise_duty;
      end else if (left_on && !right_on) begin
         first_rsp.left_dir   = DIR_FWD;
         first_rsp.left_duty  = turn_duty;
         first_rsp.right_dir  = DIR_REV;
         first_rsp.right_duty = cfg.back_duty;
      end else if (!left_on && right_on) begin
         first_rsp.left_dir   = DIR_REV;
         first_rsp.left_duty  = cfg.back_duty;
         first_rsp.right_dir  = DIR_FWD;
         first_rsp.right_duty = turn_duty;
      end else begin
         first_rsp.left_dir   = DIR_FWD;
         first_rsp.left_duty  = base_60;
         first_rsp.right_dir  = DIR_FWD;
         first_rsp.right_duty = base_60;
      end
   end

   // Filter state; obstacle items leave it untouched
   always_ff @(posedge clock) begin
      if (reset) begin
         left_hist_ff  <= '0;
         right_hist_ff <= '0;
         slot_ff       <= '0;
         reliable_ff   <= 1'b1;
         seen_ff       <= '0;
      end else if (commit && !obstacle) begin
         left_hist_ff  <= left_hist_in;
         right_hist_ff <= right_hist_in;
         slot_ff       <= slot_in;
         reliable_ff   <= reliable_in;
         seen_ff       <= seen_in;
      end
   end

endmodule

// ===== sv/line_follow_drive_controller.sv =====
// Channel   Ports                       Moves
// req       req_valid/ready, req_data   sensor item in
// rsp       rsp_valid/ready, rsp_data   timed drive command out
// csr       csr_we, csr_index, csr_wdata register write, no wait
//
// An item waits in the input register and is decided on its way into the
// result register, from which its first result is offered; a full result
// register keeps the item waiting until its last result is taken.
// A line-following item gives one result; one item per cycle is sustained
// while rsp does not stall. An obstacle item gives four results; the result
// register sequences them and holds the input register meanwhile.
// A stall on rsp holds the result register and, once the input register is
// full, drops req_ready. Reset is synchronous and clears all control state.
`include "assert_macros.svh"

module line_follow_drive_controller
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lfdc_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lfdc_pkg::rsp_type       rsp_data,
   input  logic                    csr_we,
   input  lfdc_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata
);
   import lfdc_pkg::*;

   cfg_type cfg_ff;
   req_type item_ff;
   logic    in_valid_ff;
   logic    out_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic    obst_ff;
   logic [1:0] step_ff;

   rsp_type first_rsp;
   logic    obstacle;
   logic    move;
   logic    rsp_xfer;

   // Move the decided item into the result register when it frees up
   assign rsp_xfer  = out_valid_ff && rsp_ready;
   assign move      = in_valid_ff && (!out_valid_ff || (rsp_xfer && rsp_ff.last));
   assign req_ready = !in_valid_ff || move;

   lfdc_filter u_filter (
      .clock     (clock),
      .reset     (reset),
      .commit    (move),
      .item      (item_ff),
      .cfg       (cfg_ff),
      .first_rsp (first_rsp),
      .obstacle  (obstacle)
   );

   // Next step of the obstacle sequence
   always_comb begin
      rsp_in            = rsp_ff;
      rsp_in.left_dir   = DIR_STOP;
      rsp_in.left_duty  = '0;
      rsp_in.right_dir  = DIR_STOP;
      rsp_in.right_duty = '0;
      rsp_in.last       = 1'b0;
      case (step_ff)
         STEP_STOP: begin
            rsp_in.left_dir    = DIR_REV;
            rsp_in.left_duty   = cfg_ff.back_duty;
            rsp_in.right_dir   = DIR_REV;
            rsp_in.right_duty  = cfg_ff.back_duty;
            rsp_in.servo_angle = clamp_angle(cfg_ff.center_angle);
            rsp_in.hold_ms     = HOLD_REV_MS;
         end
         STEP_REV: begin
            rsp_in.servo_angle = clamp_angle(cfg_ff.look_angle);
            rsp_in.hold_ms     = HOLD_LOOK_MS;
         end
         default: begin
            rsp_in.servo_angle = clamp_angle(cfg_ff.center_angle);
            rsp_in.hold_ms     = HOLD_STOP_MS;
            rsp_in.last        = 1'b1;
         end
      endcase
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         item_ff <= req_data;
      end
   end

   // Result register and obstacle step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         obst_ff      <= 1'b0;
         step_ff      <= STEP_STOP;
      end else if (move) begin
         out_valid_ff <= 1'b1;
         obst_ff      <= obstacle;
         step_ff      <= STEP_STOP;
         rsp_ff       <= first_rsp;
      end else if (rsp_xfer) begin
         if (rsp_ff.last) begin
            out_valid_ff <= 1'b0;
         end else begin
            step_ff <= step_ff + 2'd1;
            rsp_ff  <= rsp_in;
         end
      end
   end

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.obstacle_limit_cm <= 9'd10;
         cfg_ff.cruise_duty       <= 8'd90;
         cfg_ff.steer_duty        <= 8'd70;
         cfg_ff.back_duty         <= 8'd70;
         cfg_ff.fault_timeout_ms  <= 16'd5000;
         cfg_ff.line_level        <= 1'b0;
         cfg_ff.look_angle        <= 8'd150;
         cfg_ff.center_angle      <= 8'd90;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OBSTACLE_LIMIT: cfg_ff.obstacle_limit_cm <= csr_wdata[8:0];
            CSR_CRUISE_DUTY:    cfg_ff.cruise_duty       <= csr_wdata[7:0];
            CSR_STEER_DUTY:     cfg_ff.steer_duty        <= csr_wdata[7:0];
            CSR_BACK_DUTY:      cfg_ff.back_duty         <= csr_wdata[7:0];
            CSR_FAULT_TIMEOUT:  cfg_ff.fault_timeout_ms  <= csr_wdata;
            CSR_LINE_LEVEL:     cfg_ff.line_level        <= csr_wdata[0];
            CSR_LOOK_ANGLE:     cfg_ff.look_angle        <= csr_wdata[7:0];
            CSR_CENTER_ANGLE:   cfg_ff.center_angle      <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequence consistency
   `ASSERT_IMPLY(a_last_matches_step, clock, reset, out_valid_ff, (rsp_ff.last == (!obst_ff || (step_ff == STEP_CENTER))))
   `ASSERT_IMPLY(a_step_only_obstacle, clock, reset, out_valid_ff && (step_ff != STEP_STOP), obst_ff)
   `ASSERT_IMPLY(a_hold_only_obstacle, clock, reset, out_valid_ff, ((rsp_ff.hold_ms == 10'd0) == !obst_ff))
   `ASSERT_NEXT(a_more_follow, clock, reset, rsp_xfer && !rsp_ff.last, out_valid_ff && obst_ff)

endmodule
